FILE: hw/rtl/bbid_pkg.sv
// Shared constants, codes and types of the byte buffer insert/delete core.
package bbid_pkg;

    localparam int BUF_DEPTH   = 256;
    localparam int AW          = $clog2(BUF_DEPTH);
    localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
    localparam int POS_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 9;
    localparam int MODE_W      = 2;
    localparam int ST_W        = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_APPEND,
        OP_INSERT,
        OP_DELETE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_status status;
        t_op     op;
    } t_decision;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_DEL,
        S_READ
    } t_state;

endpackage

FILE: hw/rtl/byte_buffer_insert_delete_core.sv
// Top level of the byte buffer core: edit sequencer, buffer memory and result register.
//
//  channel  | dir | tdata (low bit up)               | tuser
//  ---------+-----+----------------------------------+---------------
//  s (edit) | in  | position[7:0], data_byte[15:8]   | mode[1:0]
//  m (res)  | out | length[8:0], read_byte[16:9], 0s | status[1:0]
//
// An append, a rejected edit, an insert at the end or a delete of the last byte needs
// no shift; a read waits on the registered read; an insert at p moves bytes p..end up
// and a delete moves those after p down, as the single read port moves one byte a cycle.
// Reset clears the length and the control state only; the memory is not cleared.
// Edits are taken only while the sequencer is idle; a finished result sits in the
// output register, and the next edit is taken while that result is being accepted.
module byte_buffer_insert_delete_core
    import bbid_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // position[7:0], data_byte[15:8]
    input  logic [MODE_W-1:0]      i_s_tuser,   // mode[1:0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // length[8:0], read_byte[16:9], zero pad
    output logic [ST_W-1:0]        o_m_tuser    // status[1:0]
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [AW-1:0]      r_pos, n_pos;
    logic [BYTE_W-1:0]  r_byte, n_byte;
    logic               r_out_valid;
    logic [LEN_W-1:0]   r_out_len;
    logic [BYTE_W-1:0]  r_out_rd;
    t_status            r_out_st;

    logic [BYTE_W-1:0]  r_mem [BUF_DEPTH];
    logic [BYTE_W-1:0]  r_rdata;

    t_decision          dec;
    logic               s_ready;
    logic               accept;
    logic [AW-1:0]      pos_a;
    logic [AW-1:0]      fill_a;
    logic [AW-1:0]      last_a;
    logic [BYTE_W-1:0]  in_byte;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      wa;
    logic [BYTE_W-1:0]  wd;
    logic               load;
    logic [BYTE_W-1:0]  ld_rd;
    t_status            ld_st;

    bbid_check u_check (
        .i_mode     (t_mode'(i_s_tuser)),
        .i_position (i_s_tdata[POS_W-1:0]),
        .i_fill     (r_fill),
        .o_decision (dec)
    );

    assign pos_a   = AW'(i_s_tdata[POS_W-1:0]);
    assign in_byte = i_s_tdata[POS_W +: BYTE_W];
    assign fill_a  = AW'(r_fill);
    assign last_a  = AW'(r_fill - CNT_W'(1));
    assign s_ready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept  = s_ready && i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_pos  <= n_pos;
        r_byte <= n_byte;
        if (load) begin
            r_out_len <= LEN_W'(n_fill);
            r_out_rd  <= ld_rd;
            r_out_st  <= ld_st;
        end
    end

    // Shifts register each read in the read data register ahead of its write, the write address
    // trailing the read address, so the same entry is never read and written in one cycle.
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_ptr   = r_ptr;
        n_pos   = r_pos;
        n_byte  = r_byte;
        rd_addr = r_ptr;
        we      = 1'b0;
        wa      = r_ptr;
        wd      = r_rdata;
        load    = 1'b0;
        ld_rd   = '0;
        ld_st   = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (dec.op)
                        OP_NONE: begin
                            load  = 1'b1;
                            ld_st = dec.status;
                        end
                        OP_APPEND: begin
                            we     = 1'b1;
                            wa     = fill_a;
                            wd     = in_byte;
                            n_fill = r_fill + CNT_W'(1);
                            load   = 1'b1;
                        end
                        OP_INSERT: begin
                            if (pos_a == fill_a) begin
                                we     = 1'b1;
                                wa     = pos_a;
                                wd     = in_byte;
                                n_fill = r_fill + CNT_W'(1);
                                load   = 1'b1;
                            end else begin
                                rd_addr = last_a;
                                n_ptr   = last_a;
                                n_pos   = pos_a;
                                n_byte  = in_byte;
                                n_state = S_INS;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_a == last_a) begin
                                n_fill = r_fill - CNT_W'(1);
                                load   = 1'b1;
                            end else begin
                                rd_addr = pos_a + AW'(1);
                                n_ptr   = pos_a + AW'(1);
                                n_state = S_DEL;
                            end
                        end
                        OP_READ: begin
                            rd_addr = pos_a;
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS: begin
                we = 1'b1;
                wa = r_ptr + AW'(1);
                wd = r_rdata;
                if (r_ptr == r_pos) begin
                    n_state = S_INS_LAST;
                end else begin
                    rd_addr = r_ptr - AW'(1);
                    n_ptr   = r_ptr - AW'(1);
                end
            end
            S_INS_LAST: begin
                we      = 1'b1;
                wa      = r_pos;
                wd      = r_byte;
                n_fill  = r_fill + CNT_W'(1);
                load    = 1'b1;
                n_state = S_IDLE;
            end
            S_DEL: begin
                we = 1'b1;
                wa = r_ptr - AW'(1);
                wd = r_rdata;
                if (r_ptr == last_a) begin
                    n_fill  = r_fill - CNT_W'(1);
                    load    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr = r_ptr + AW'(1);
                    n_ptr   = r_ptr + AW'(1);
                end
            end
            S_READ: begin
                load    = 1'b1;
                ld_rd   = r_rdata;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_rd, r_out_len});
    assign o_m_tuser  = r_out_st;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(BUF_DEPTH))
        else $error("buffer length beyond depth");

    a_fill_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> r_out_valid)
        else $error("length changed without a result");

    a_ins_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_ptr >= r_pos && CNT_W'(r_ptr) < r_fill))
        else $error("insert shift pointer outside its span");

    a_del_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) |-> (r_ptr != '0 && CNT_W'(r_ptr) < r_fill))
        else $error("delete shift pointer outside its span");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS || r_state == S_DEL || r_state == S_INS_LAST) |-> !r_out_valid)
        else $error("result pending during a shift");

endmodule

FILE: hw/rtl/bbid_check.sv
// Bounds and occupancy checks that decide what an edit does.
module bbid_check
    import bbid_pkg::*;
(
    input  t_mode            i_mode,
    input  logic [POS_W-1:0] i_position,
    input  logic [CNT_W-1:0] i_fill,
    output t_decision        o_decision
);

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] fill_ext;
    logic             full;
    logic             empty;

    assign pos_ext  = CMP_W'(i_position);
    assign fill_ext = CMP_W'(i_fill);
    assign full     = (i_fill >= CNT_W'(BUF_DEPTH));
    assign empty    = (i_fill == '0);

    always_comb begin
        o_decision.status = ST_OK;
        o_decision.op     = OP_NONE;
        case (i_mode)
            MODE_APPEND: begin
                if (full) begin
                    o_decision.status = ST_FULL;
                end else begin
                    o_decision.op = OP_APPEND;
                end
            end
            MODE_INSERT: begin
                // A full buffer is reported ahead of a bad position.
                if (full) begin
                    o_decision.status = ST_FULL;
                end else if (pos_ext > fill_ext) begin
                    o_decision.status = ST_RANGE;
                end else begin
                    o_decision.op = OP_INSERT;
                end
            end
            MODE_DELETE: begin
                if (empty) begin
                    o_decision.status = ST_EMPTY;
                end else if (pos_ext >= fill_ext) begin
                    o_decision.status = ST_RANGE;
                end else begin
                    o_decision.op = OP_DELETE;
                end
            end
            MODE_READ: begin
                if (empty) begin
                    o_decision.status = ST_EMPTY;
                end else if (pos_ext >= fill_ext) begin
                    o_decision.status = ST_RANGE;
                end else begin
                    o_decision.op = OP_READ;
                end
            end
            default: begin
                o_decision.op = OP_NONE;
            end
        endcase
    end

endmodule
